// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge, off while reset is held.
`define CSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lexer assertion failed");

// Check that a condition never holds.
`define CSL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (!(cond))) \
        else $error("lexer forbidden condition seen");

`else

`define CSL_ASSERT(lbl, clk, rst_n, prop)
`define CSL_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/csl_pkg.sv =====
package csl_pkg;

    // Lexer modes; unused codes behave as normal text.
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_BSTAR  = 3'd4
    } mode_t;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_PUNCT = 1'b1;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One character of a token.
    typedef struct packed {
        logic [7:0] chr;
        logic       kind;
        logic       done;
    } tok_t;

    // Results caused by one input byte: one or two tokens.
    typedef struct packed {
        tok_t first;
        tok_t second;
        logic two;
    } entry_t;

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == 8'h28) || (c == 8'h29) || (c == 8'h5B) || (c == 8'h5D) ||
               (c == 8'h7B) || (c == 8'h7D) || (c == 8'h3B) || (c == 8'h2C) ||
               (c == 8'h3D) || (c == CH_STAR) || (c == CH_SLASH) ||
               (c == 8'h2D) || (c == 8'h26) || (c == 8'h3C) || (c == 8'h3E);
    endfunction

endpackage

// ===== rtl/core/comment_stripping_lexer.sv =====
// Comment-stripping lexer for C-like source text.
// Input channel: present text_byte and text_end with push; a byte transfers
// at a rising edge with push high and full low. Set text_end on the last byte
// of a text to flush a held word character or pending slash.
// Result channel: while empty is low the oldest token character sits on
// token_byte, token_kind, token_done and run_last; it transfers at a rising
// edge with pop high. run_last marks the final result caused by one byte.
// Throughput: one byte per cycle while full is low. A byte that yields two
// results holds the output stage until both have transferred; a four-entry
// queue between the classifier and the output stage absorbs these bursts, so
// full rises only once four result-bearing bytes wait behind the output stage.
// Path: the results of a byte are written into the queue as the byte transfers
// and move into the output stage register once it is free; word characters
// leave one byte later, once the next byte shows whether the word goes on.
// Reset: all modes clear to normal text, nothing held, queue and output empty.
// A stalled receiver fills the queue and then holds full high; nothing drops.
module comment_stripping_lexer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       text_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] token_byte,
    output logic       token_kind,
    output logic       token_done,
    output logic       run_last
);

    logic            wr_en;
    csl_pkg::entry_t wr_entry;
    logic            rd_en;
    csl_pkg::entry_t rd_entry;
    logic            q_full;
    logic            q_empty;

    // Front: classify each byte, track comment mode and the held character.
    csl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .text_end  (text_end),
        .q_full    (q_full),
        .wr_en     (wr_en),
        .wr_entry  (wr_entry)
    );

    // Queue: hold the results of each byte until the back is free.
    csl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_entry (rd_entry),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    // Back: hand out the results of each entry one per transfer.
    csl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_entry   (rd_entry),
        .q_empty    (q_empty),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .token_byte (token_byte),
        .token_kind (token_kind),
        .token_done (token_done),
        .run_last   (run_last)
    );

    assign full = q_full;

endmodule

// ===== rtl/core/csl_front.sv =====
module csl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [7:0]      text_byte,
    input  logic            text_end,
    input  logic            q_full,
    output logic            wr_en,
    output csl_pkg::entry_t wr_entry
);

    csl_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     held_char_reg, held_char_next;
    logic           held_valid_reg, held_valid_next;

    csl_pkg::tok_t  res [2];
    logic [1:0]     n;
    logic           do_plain;
    logic           accept;

    assign accept = push && !q_full;

    always_comb
    begin
        n               = 2'd0;
        res[0]          = '0;
        res[1]          = '0;
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        do_plain        = 1'b0;

        unique case (mode_reg)
            csl_pkg::MODE_SLASH:
            begin
                if (text_byte == csl_pkg::CH_SLASH)
                    mode_next = csl_pkg::MODE_LINE;
                else if (text_byte == csl_pkg::CH_STAR)
                    mode_next = csl_pkg::MODE_BLOCK;
                else
                begin
                    res[0]   = '{chr: csl_pkg::CH_SLASH, kind: csl_pkg::KIND_PUNCT,
                                 done: 1'b1};
                    n        = 2'd1;
                    do_plain = 1'b1;
                end
            end
            csl_pkg::MODE_LINE:
            begin
                if (text_byte == csl_pkg::CH_LF)
                    mode_next = csl_pkg::MODE_NORMAL;
            end
            csl_pkg::MODE_BLOCK:
            begin
                if (text_byte == csl_pkg::CH_STAR)
                    mode_next = csl_pkg::MODE_BSTAR;
            end
            csl_pkg::MODE_BSTAR:
            begin
                if (text_byte == csl_pkg::CH_SLASH)
                    mode_next = csl_pkg::MODE_NORMAL;
                else if (text_byte != csl_pkg::CH_STAR)
                    mode_next = csl_pkg::MODE_BLOCK;
            end
            default:
            begin
                if (held_valid_reg)
                begin
                    n = 2'd1;
                    if (csl_pkg::is_word(text_byte))
                    begin
                        // word goes on: release the held character unfinished
                        res[0]         = '{chr: held_char_reg, kind: csl_pkg::KIND_WORD,
                                           done: 1'b0};
                        held_char_next = text_byte;
                    end
                    else
                    begin
                        res[0]          = '{chr: held_char_reg, kind: csl_pkg::KIND_WORD,
                                            done: 1'b1};
                        held_char_next  = 8'd0;
                        held_valid_next = 1'b0;
                        do_plain        = 1'b1;
                    end
                end
                else
                    do_plain = 1'b1;
            end
        endcase

        if (do_plain)
        begin
            mode_next = csl_pkg::MODE_NORMAL;
            if (csl_pkg::is_word(text_byte))
            begin
                held_char_next  = text_byte;
                held_valid_next = 1'b1;
            end
            else if (text_byte == csl_pkg::CH_SLASH)
                mode_next = csl_pkg::MODE_SLASH;
            else if (csl_pkg::is_punct(text_byte))
            begin
                res[n[0]] = '{chr: text_byte, kind: csl_pkg::KIND_PUNCT, done: 1'b1};
                n         = n + 2'd1;
            end
        end

        // end of text: flush whatever is held, drop an open comment
        if (text_end)
        begin
            if (held_valid_next)
            begin
                res[n[0]] = '{chr: held_char_next, kind: csl_pkg::KIND_WORD, done: 1'b1};
                n         = n + 2'd1;
            end
            if (mode_next == csl_pkg::MODE_SLASH)
            begin
                res[n[0]] = '{chr: csl_pkg::CH_SLASH, kind: csl_pkg::KIND_PUNCT,
                              done: 1'b1};
                n         = n + 2'd1;
            end
            held_char_next  = 8'd0;
            held_valid_next = 1'b0;
            mode_next       = csl_pkg::MODE_NORMAL;
        end

        wr_en           = accept && (n != 2'd0);
        wr_entry.first  = res[0];
        wr_entry.second = res[1];
        wr_entry.two    = n[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= csl_pkg::MODE_NORMAL;
            held_char_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// ===== rtl/core/csl_queue.sv =====
`include "assert_macros.svh"

module csl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  csl_pkg::entry_t wr_entry,
    input  logic            rd_en,
    output csl_pkg::entry_t rd_entry,
    output logic            q_full,
    output logic            q_empty
);

    csl_pkg::entry_t                 slot_reg [csl_pkg::QDEPTH];
    logic [csl_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [csl_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [csl_pkg::QCNT_W-1:0]      count_reg, count_next;

    localparam logic [csl_pkg::QPTR_W-1:0] LAST_PTR = csl_pkg::QPTR_W'(csl_pkg::QDEPTH - 1);
    localparam logic [csl_pkg::QCNT_W-1:0] FULL_CNT = csl_pkg::QCNT_W'(csl_pkg::QDEPTH);

    assign q_full   = (count_reg == FULL_CNT);
    assign q_empty  = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    `CSL_ASSERT_NEVER(a_no_overflow, clk, rst_n, wr_en && q_full)
    `CSL_ASSERT_NEVER(a_no_underflow, clk, rst_n, rd_en && q_empty)
    `CSL_ASSERT(a_fill_up, clk, rst_n, (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
    `CSL_ASSERT(a_ptr_gap, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

// ===== rtl/core/csl_back.sv =====
`include "assert_macros.svh"

module csl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  csl_pkg::entry_t rd_entry,
    input  logic            q_empty,
    output logic            rd_en,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      token_byte,
    output logic            token_kind,
    output logic            token_done,
    output logic            run_last
);

    csl_pkg::entry_t cur_reg, cur_next;
    logic            valid_reg, valid_next;
    logic            sel_reg, sel_next;
    logic            is_last;
    logic            taken;
    csl_pkg::tok_t   tok;

    assign is_last = sel_reg || !cur_reg.two;
    assign taken   = pop && valid_reg;
    assign tok     = sel_reg ? cur_reg.second : cur_reg.first;

    assign empty      = !valid_reg;
    assign token_byte = tok.chr;
    assign token_kind = tok.kind;
    assign token_done = tok.done;
    assign run_last   = is_last;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        rd_en      = (!valid_reg || (taken && is_last)) && !q_empty;
        priority if (taken && !is_last)
            sel_next = 1'b1;
        else if (rd_en)
        begin
            cur_next   = rd_entry;
            valid_next = 1'b1;
            sel_next   = 1'b0;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
            sel_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    `CSL_ASSERT(a_second_needs_pair, clk, rst_n, sel_reg |-> (valid_reg && cur_reg.two))
    `CSL_ASSERT(a_pair_advances, clk, rst_n, (taken && !sel_reg && cur_reg.two) |=> (valid_reg && sel_reg))
    `CSL_ASSERT(a_hold_on_stall, clk, rst_n, (valid_reg && !pop) |=> (valid_reg && $stable(sel_reg)))

endmodule
